### src/asp_pkg.sv
// asp_pkg: shared types and constants for the length-two path counter.
// No dependencies; used by every other file of the block except asp_ram.
`default_nettype none
package asp_pkg;

  localparam int MAX_NODES  = 32;
  localparam int ROW_SLOTS  = 32;
  localparam int ROW_W      = 32;
  localparam int IDX_W      = 5;
  localparam int CNT_W      = 6;
  localparam int NODE_LIMIT = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(32);
  localparam logic [CNT_W-1:0] NODE_MIN       = CNT_W'(2);
  localparam logic [CNT_W-1:0] NODE_MAX       = CNT_W'(NODE_LIMIT);

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEL,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic write_row;    // store request row into the row memory
    logic read_row;     // read queried row, clear sums and counters
    logic capture_sel;  // latch queried row as selector
    logic scan_issue;   // read row k, advance k
    logic emit_step;    // one result taken, shift sums
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;    // k is the final vertex
    logic emit_last;    // j is the final column
  } status_t;

endpackage
`default_nettype wire

### src/asp_if.sv
// Request and result channel interfaces (valid/ready handshake).
// Depends on asp_pkg for field widths.
`default_nettype none
interface asp_req_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [asp_pkg::IDX_W-1:0]  row_index;
  logic [asp_pkg::ROW_W-1:0]  row_bits;

  modport source (output valid, output mode, output row_index, output row_bits,
                  input ready);
  modport sink   (input valid, input mode, input row_index, input row_bits,
                  output ready);
endinterface

interface asp_res_if;
  logic                       valid;
  logic                       ready;
  logic [asp_pkg::IDX_W-1:0]  column_index;
  logic [asp_pkg::CNT_W-1:0]  path_count;
  logic                       last;

  modport source (output valid, output column_index, output path_count, output last,
                  input ready);
  modport sink   (input valid, input column_index, input path_count, input last,
                  output ready);
endinterface
`default_nettype wire

### src/asp_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module asp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

### src/asp_ctrl.sv
// Sequencer for the path counter: load, select read, row scan, drain, emit.
// Depends on asp_pkg.
`default_nettype none
module asp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  input  wire logic             req_mode,
  output logic                  req_ready,
  output logic                  res_valid,
  input  wire logic             res_ready,
  input  wire asp_pkg::status_t stat,
  output asp_pkg::cmd_t         cmd
);
  import asp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    res_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req_mode == MODE_LOAD) begin
            cmd.write_row = 1'b1;
          end else begin
            cmd.read_row = 1'b1;
            state_next   = S_SEL;
          end
        end
      end
      S_SEL: begin
        cmd.capture_sel = 1'b1;
        state_next      = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last row read lands and is added this cycle
        state_next = S_EMIT;
      end
      S_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          cmd.emit_step = 1'b1;
          if (stat.emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### src/asp_dp.sv
// Datapath: node count register, row memory, selector, per-column sum lanes.
// Depends on asp_pkg and asp_ram.
`default_nettype none
module asp_dp (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [asp_pkg::CNT_W-1:0] cfg_wr_data,
  input  wire logic [asp_pkg::IDX_W-1:0] row_index,
  input  wire logic [asp_pkg::ROW_W-1:0] row_bits,
  input  wire asp_pkg::cmd_t             cmd,
  output asp_pkg::status_t               stat,
  output logic      [asp_pkg::IDX_W-1:0] column_index,
  output logic      [asp_pkg::CNT_W-1:0] path_count
);
  import asp_pkg::*;

  logic [CNT_W-1:0] node_count;
  logic [CNT_W-1:0] n_eff;
  logic [IDX_W-1:0] n_last;
  logic [ROW_W-1:0] mask;
  logic [ROW_W-1:0] sel;
  logic [ROW_W-1:0] rd_data;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] j;
  logic             acc_en;
  logic [IDX_W-1:0] raddr;
  logic [CNT_W-1:0] sums [ROW_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
    end else if (cfg_wr_en) begin
      node_count <= cfg_wr_data;
    end
  end

  // saturate into [2, limit]
  always_comb begin
    if (node_count < NODE_MIN) begin
      n_eff = NODE_MIN;
    end else if (node_count > NODE_MAX) begin
      n_eff = NODE_MAX;
    end else begin
      n_eff = node_count;
    end
    n_last = IDX_W'(n_eff - CNT_W'(1));
    for (int b = 0; b < ROW_W; b++) begin
      mask[b] = (CNT_W'(b) < n_eff);
    end
  end

  assign raddr = cmd.scan_issue ? k : row_index;

  asp_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROW_SLOTS)
  ) u_rows (
    .clk   (clk),
    .we    (cmd.write_row),
    .waddr (row_index),
    .wdata (row_bits),
    .re    (cmd.read_row | cmd.scan_issue),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_en <= 1'b0;
    end else begin
      acc_en <= cmd.scan_issue & sel[k];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_row) begin
      k <= '0;
      j <= '0;
    end else begin
      if (cmd.scan_issue) begin
        k <= k + IDX_W'(1);
      end
      if (cmd.emit_step) begin
        j <= j + IDX_W'(1);
      end
    end
    if (cmd.capture_sel) begin
      sel <= rd_data & mask;
    end
  end

  // sum lanes: cleared per query, add selected rows, shift out during emit
  always_ff @(posedge clk) begin
    for (int c = 0; c < ROW_SLOTS; c++) begin
      if (cmd.read_row) begin
        sums[c] <= '0;
      end else if (acc_en) begin
        sums[c] <= sums[c] + CNT_W'(rd_data[c] & mask[c]);
      end else if (cmd.emit_step) begin
        if (c == ROW_SLOTS - 1) begin
          sums[c] <= '0;
        end else begin
          sums[c] <= sums[c+1];
        end
      end
    end
  end

  assign stat.scan_last = (k == n_last);
  assign stat.emit_last = (j == n_last);
  assign column_index   = j;
  assign path_count     = sums[0];
endmodule
`default_nettype wire

### src/adjacency_square_path_count.sv
// Top level of the length-two path counter (adjacency matrix squaring).
// Depends on asp_pkg, asp_if, asp_ctrl, asp_dp (which holds asp_ram).
//
//   port          | dir | what moves
//   --------------+-----+-----------------------------------------------
//   request       | in  | mode, row_index, row_bits (load or query)
//   result        | out | column_index, path_count, last (n per query)
//   cfg_wr_*      | in  | node_count write, no read-back
//
// A load request writes the row memory in the cycle it is accepted.
// A query reads the named row, latches it as selector, reads rows 0..n-1
// via the single memory read port, adds the last row, then emits n results.
// Synchronous reset clears the controller, the sum-add flag and node_count
// (to 32); row memory contents stay undefined until written.
// Only one request is in flight: request.ready is low from query accept
// until the last result is taken; a stalled result simply holds.
`default_nettype none
module adjacency_square_path_count (
  input  wire logic                      clk,
  input  wire logic                      rst,
  asp_req_if.sink                        request,
  asp_res_if.source                      result,
  input  wire logic                      cfg_wr_en,
  input  wire logic [asp_pkg::CNT_W-1:0] cfg_wr_data
);
  import asp_pkg::*;

  cmd_t    cmd;
  status_t stat;

  // Sequencer: owns both handshakes, drives datapath commands.
  asp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_mode  (request.mode),
    .req_ready (request.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: row memory, selector, 32 sum lanes that shift out one
  // column per accepted result, so path_count comes straight from a flop.
  asp_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .row_index    (request.row_index),
    .row_bits     (request.row_bits),
    .cmd          (cmd),
    .stat         (stat),
    .column_index (result.column_index),
    .path_count   (result.path_count)
  );

  // final column flag comes from the column counter compare
  assign result.last = stat.emit_last;
endmodule
`default_nettype wire

### test/asp_path_checker.sv
`timescale 1ns / 100ps
// asp_path_checker: watches the request, result and node_count ports, predicts
// the length-two path counts of every query and compares each result in order.
// Depends on asp_pkg and the channel interfaces in asp_if.
module asp_path_checker (
  input  wire logic                      clk,
  input  wire logic                      rst,
  asp_req_if                             request,
  asp_res_if                             result,
  input  wire logic                      cfg_wr_en,
  input  wire logic [asp_pkg::CNT_W-1:0] cfg_wr_data,
  output int                             errors,
  output int                             pending,
  output int                             checked
);
  import asp_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] column;
    logic [CNT_W-1:0] count;
    logic             last;
  } path_count_t;

  logic [ROW_W-1:0] adjacency [ROW_SLOTS];
  logic [CNT_W-1:0] node_count;
  path_count_t      path_q [$];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  // Square one row: add every row k picked by the queried row, masked to n.
  function automatic void predict_paths(input logic [IDX_W-1:0] row);
    int               n;
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] sel;
    logic [ROW_W-1:0] other;
    logic [CNT_W-1:0] sums [ROW_SLOTS];
    path_count_t      entry;
    n = int'(node_count);
    if (n < int'(NODE_MIN)) n = int'(NODE_MIN);
    if (n > int'(NODE_MAX)) n = int'(NODE_MAX);
    mask = (n >= ROW_W) ? '1 : ((ROW_W'(1) << n) - ROW_W'(1));
    sel = adjacency[row] & mask;
    foreach (sums[j]) sums[j] = '0;
    for (int k = 0; k < n; k++) begin
      if (sel[k]) begin
        other = adjacency[k] & mask;
        for (int j = 0; j < n; j++) sums[j] = sums[j] + CNT_W'(other[j]);
      end
    end
    for (int j = 0; j < n; j++) begin
      entry.column = IDX_W'(j);
      entry.count  = sums[j];
      entry.last   = (j == n - 1);
      path_q.push_back(entry);
    end
  endfunction

  task automatic compare_result();
    path_count_t want;
    if (path_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result column %0d count %0d last %0b",
                                result.column_index, result.path_count, result.last));
      return;
    end
    want = path_q.pop_front();
    if (result.column_index !== want.column)
      report_mismatch($sformatf("column_index %0d, want %0d",
                                result.column_index, want.column));
    if (result.path_count !== want.count)
      report_mismatch($sformatf("path_count %0d at column %0d, want %0d",
                                result.path_count, want.column, want.count));
    if (result.last !== want.last)
      report_mismatch($sformatf("last %0b at column %0d, want %0b",
                                result.last, want.column, want.last));
    checked++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      node_count = NODE_COUNT_RST;
      path_q.delete();
      errors  = 0;
      checked = 0;
    end else begin
      if (result.valid && result.ready) compare_result();
      if (request.valid && request.ready) begin
        if (request.mode == MODE_LOAD) adjacency[request.row_index] = request.row_bits;
        else predict_paths(request.row_index);
      end
      if (cfg_wr_en) node_count = cfg_wr_data;
    end
    pending = path_q.size();
  end

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// tb: drives row loads, queries and node_count writes into the path counter
// with random gaps and result stalls; asp_path_checker judges every result.
// Depends on asp_pkg, asp_if, adjacency_square_path_count and asp_path_checker.
module tb;
  import asp_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 27;

  logic clk = 1'b0;
  logic rst;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;

  // Idle knobs, redrawn per phase: when set, that side never waits.
  logic req_calm = 1'b0;
  logic res_calm = 1'b0;

  int errors;
  int pending;
  int checked;
  int loads      = 0;
  int queries    = 0;
  int cfg_writes = 0;

  asp_req_if request_ch ();
  asp_res_if result_ch ();

  always #6 clk = ~clk;

  adjacency_square_path_count i_dut (
    .clk         (clk),
    .rst         (rst),
    .request     (request_ch),
    .result      (result_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  asp_path_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .request     (request_ch),
    .result      (result_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .errors      (errors),
    .pending     (pending),
    .checked     (checked)
  );

  // One request: optional random gap with valid low, then hold the request
  // until the edge where ready is seen. Returns on the accepting edge with
  // valid still high, so a back-to-back request needs no second assignment.
  task automatic send_request(input logic item_mode, input logic [IDX_W-1:0] row,
                              input logic [ROW_W-1:0] bits);
    int gap;
    gap = req_calm ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      request_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_ch.valid     <= 1'b1;
    request_ch.mode      <= item_mode;
    request_ch.row_index <= row;
    request_ch.row_bits  <= bits;
    do @(posedge clk); while (!request_ch.ready);
    if (item_mode == MODE_LOAD) loads++;
    else queries++;
  endtask

  // Block is idle once every expected count is in and the datapath had time
  // to finish anything a trailing load may still be doing.
  task automatic wait_idle();
    request_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [CNT_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_writes++;
  endtask

  // Result side: random stall before each result, ready kept high when the
  // next draw is zero so ready never toggles within one step.
  initial begin : result_sink
    int gap;
    result_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = res_calm ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  initial begin : stimulus
    logic [ROW_W-1:0] bits;
    logic [CNT_W-1:0] plan [PHASES];
    rst                  <= 1'b1;
    cfg_wr_en            <= 1'b0;
    cfg_wr_data          <= '0;
    request_ch.valid     <= 1'b0;
    request_ch.mode      <= MODE_LOAD;
    request_ch.row_index <= '0;
    request_ch.row_bits  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset node_count of 32. Every row is written
    // first, so no query ever reads an unwritten row afterwards.
    for (int k = 0; k < ROW_SLOTS; k++) send_request(MODE_LOAD, IDX_W'(k), '1);
    send_request(MODE_QUERY, IDX_W'(0), '0);            // every count at its maximum
    send_request(MODE_LOAD, IDX_W'(7), '0);
    send_request(MODE_QUERY, IDX_W'(7), '1);            // empty row, all counts zero
    send_request(MODE_LOAD, IDX_W'(0), 32'h8000_0001);  // only the end vertices
    send_request(MODE_QUERY, IDX_W'(0), '0);
    send_request(MODE_QUERY, IDX_W'(31), '0);           // mixes full, sparse, empty rows

    // Random phases. Settings include the low end, the top, values above and
    // below the legal range (saturated by the block) and a random one; with a
    // small n most queried rows sit at or above n.
    plan = '{CNT_W'(2), CNT_W'(63), CNT_W'(0), CNT_W'(17), CNT_W'(1),
             CNT_W'(32), CNT_W'(45), CNT_W'(5), CNT_W'(32), CNT_W'(2)};
    plan[PHASES-1] = CNT_W'($urandom_range(3, 31));
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_node_count(plan[p]);
      req_calm = ($urandom_range(0, 3) == 0);
      res_calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        case ($urandom_range(0, 7))
          0:       bits = '0;
          1:       bits = '1;
          2, 3:    bits = $urandom() & $urandom() & $urandom();
          default: bits = $urandom();
        endcase
        if ($urandom_range(0, 9) < 4)
          send_request(MODE_LOAD, IDX_W'($urandom_range(0, 31)), bits);
        else
          send_request(MODE_QUERY, IDX_W'($urandom_range(0, 31)), bits);
      end
    end

    wait_idle();
    $display("covered %0d row loads and %0d queries across %0d node_count writes",
             loads, queries, cfg_writes);
    $display("checked %0d path counts, %0d mismatches", checked, errors);
    if (errors == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d path counts outstanding", cycles, pending);
    $display("status: fail");
    $finish;
  end

endmodule
